// File: rtl/core/isa_pkg.sv
// ----------------------------------------------------------------------------
// Index slot allocator package
// Shared constants, codes and structures of the slot allocator.
// ----------------------------------------------------------------------------
package isa_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int MIN_ENTRIES = 32;
    localparam int SLOT_W      = 12;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = ADDR_W + 1;

    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] HALF_CNT = CNT_W'(MAX_ENTRIES / 2);
    localparam logic [CNT_W-1:0] MIN_CAP  =
        CNT_W'((MIN_ENTRIES > MAX_ENTRIES) ? MAX_ENTRIES : MIN_ENTRIES);

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_CLAIM   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_IN_USE = 2'd2,
        STATUS_RANGE  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GROW,
        ST_CLAIM_CHK,
        ST_ALLOC,
        ST_POP_WAIT,
        ST_ALLOC_CHK,
        ST_REL_CHK,
        ST_CMP_MARK,
        ST_CMP_SCAN,
        ST_REL_PUSH,
        ST_DONE
    } state_t;

    // Request to a one-bit-wide map memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic [ADDR_W-1:0] raddr;
    } bit_req_t;

    // Request to the free stack memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [SLOT_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } stack_req_t;

    // Bookkeeping counters, visible to the top level for checking.
    typedef struct packed {
        logic [CNT_W-1:0] depth;
        logic [CNT_W-1:0] bump;
        logic [CNT_W-1:0] cap;
    } isa_stat_t;

endpackage

// File: rtl/core/isa_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one allocate, claim or release transaction into the allocator.
// ----------------------------------------------------------------------------
interface isa_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic [isa_pkg::SLOT_W-1:0] slot;

    modport source (output valid, output kind, output slot, input ready);
    modport sink   (input valid, input kind, input slot, output ready);
endinterface

// File: rtl/core/isa_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries the status and slot index of one finished transaction.
// ----------------------------------------------------------------------------
interface isa_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [isa_pkg::SLOT_W-1:0] granted_slot;

    modport source (output valid, output status, output granted_slot, input ready);
    modport sink   (input valid, input status, input granted_slot, output ready);
endinterface

// File: rtl/core/index_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// Index slot allocator
// Hands out, claims and releases slot indices over a growing table.
// ----------------------------------------------------------------------------
// The req channel takes one transaction at a time: allocate any free slot,
// claim a given slot or release a given slot. The rsp channel returns one
// transaction per request with a status and the granted or echoed slot.
// The in-use map, the free stack and the compaction scratch map sit in three
// 4096-entry RAMs that are read, modified and written back by a sequencer;
// each RAM read is registered. A release of a slot that is not in use goes
// straight to the response. A claim first doubles the capacity until it
// covers the slot. An allocate takes a slot from the free stack, else from
// the bump pointer, or answers full when the table is full, and skips every
// stale entry that is already in use; an unknown kind goes straight to the
// response. A release that finds the free stack full first compacts it,
// sweeping the scratch map. After reset the block clears both maps with
// req.ready low.
// A finished response waits in its output register while rsp is stalled;
// the next request is taken and worked on meanwhile, and is held in its
// last step until the output register is free.
// ----------------------------------------------------------------------------
module index_slot_allocator_core (
    input logic       clk,
    input logic       rst_n,
    isa_req_if.sink   req,
    isa_rsp_if.source rsp
);

    isa_pkg::bit_req_t          map_req;
    isa_pkg::bit_req_t          scr_req;
    isa_pkg::stack_req_t        stk_req;
    logic                       map_rdata;
    logic                       scr_rdata;
    logic [isa_pkg::SLOT_W-1:0] stk_rdata;
    isa_pkg::isa_stat_t         stat;

    isa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .in_kind     (req.kind),
        .in_slot     (req.slot),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_status  (rsp.status),
        .out_granted (rsp.granted_slot),
        .map_req     (map_req),
        .map_rdata   (map_rdata),
        .scr_req     (scr_req),
        .scr_rdata   (scr_rdata),
        .stk_req     (stk_req),
        .stk_rdata   (stk_rdata),
        .stat        (stat)
    );

    isa_ram #(.WIDTH(1), .DEPTH(isa_pkg::MAX_ENTRIES)) u_map_ram (
        .clk   (clk),
        .we    (map_req.we),
        .waddr (map_req.waddr),
        .wdata (map_req.wdata),
        .raddr (map_req.raddr),
        .rdata (map_rdata)
    );

    isa_ram #(.WIDTH(1), .DEPTH(isa_pkg::MAX_ENTRIES)) u_scr_ram (
        .clk   (clk),
        .we    (scr_req.we),
        .waddr (scr_req.waddr),
        .wdata (scr_req.wdata),
        .raddr (scr_req.raddr),
        .rdata (scr_rdata)
    );

    isa_ram #(.WIDTH(isa_pkg::SLOT_W), .DEPTH(isa_pkg::MAX_ENTRIES)) u_stk_ram (
        .clk   (clk),
        .we    (stk_req.we),
        .waddr (stk_req.waddr),
        .wdata (stk_req.wdata),
        .raddr (stk_req.raddr),
        .rdata (stk_rdata)
    );

`ifndef SYNTH
    // Capacity only ever doubles from a power of two, up to the maximum.
    a_cap_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(stat.cap) && stat.cap <= isa_pkg::MAX_CNT)
        else $error("capacity is not a power of two within range");

    // The free stack never holds more entries than the capacity.
    a_depth_cap: assert property (@(posedge clk) disable iff (!rst_n)
        stat.depth <= stat.cap)
        else $error("free stack deeper than capacity");

    // The bump pointer never runs past the capacity.
    a_bump_cap: assert property (@(posedge clk) disable iff (!rst_n)
        stat.bump <= stat.cap)
        else $error("bump pointer beyond capacity");

    // A full table grants slot zero.
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == isa_pkg::STATUS_FULL |-> rsp.granted_slot == '0)
        else $error("full response carries a slot");
`endif

endmodule

// File: rtl/core/isa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module isa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/isa_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator sequencer
// Reads, modifies and writes back the in-use map, the free stack and the
// compaction scratch map, one transaction at a time.
// ----------------------------------------------------------------------------
module isa_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 in_kind,
    input  logic [isa_pkg::SLOT_W-1:0] in_slot,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 out_status,
    output logic [isa_pkg::SLOT_W-1:0] out_granted,
    output isa_pkg::bit_req_t          map_req,
    input  logic                       map_rdata,
    output isa_pkg::bit_req_t          scr_req,
    input  logic                       scr_rdata,
    output isa_pkg::stack_req_t        stk_req,
    input  logic [isa_pkg::SLOT_W-1:0] stk_rdata,
    output isa_pkg::isa_stat_t         stat
);

    isa_pkg::state_t                   state_reg, state_next;
    logic [isa_pkg::SLOT_W-1:0]        slot_reg, slot_next;
    logic [isa_pkg::ADDR_W-1:0]        idx_reg, idx_next;
    logic [isa_pkg::ADDR_W-1:0]        scan_reg, scan_next;
    logic [isa_pkg::CNT_W-1:0]         depth_reg, depth_next;
    logic [isa_pkg::CNT_W-1:0]         bump_reg, bump_next;
    logic [isa_pkg::CNT_W-1:0]         cap_reg, cap_next;
    logic [isa_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [isa_pkg::CNT_W-1:0]         n_reg, n_next;
    logic                              pend_reg, pend_next;
    isa_pkg::status_t                  status_reg, status_next;
    logic [isa_pkg::SLOT_W-1:0]        granted_reg, granted_next;
    logic                              ovalid_reg, ovalid_next;
    logic [1:0]                        ostatus_reg, ostatus_next;
    logic [isa_pkg::SLOT_W-1:0]        ogranted_reg, ogranted_next;
    logic                              in_range;
    logic                              slot_range;
    logic                              out_free;
    logic [isa_pkg::CNT_W-1:0]         cap_grown;
    logic [isa_pkg::CNT_W-1:0]         depth_dec;

    assign in_range   = ({1'b0, in_slot} < isa_pkg::MAX_CNT);
    assign slot_range = ({1'b0, slot_reg} < isa_pkg::MAX_CNT);
    assign out_free   = !ovalid_reg || out_ready;
    assign cap_grown  = (cap_reg >= isa_pkg::HALF_CNT) ? isa_pkg::MAX_CNT
                                                       : {cap_reg[isa_pkg::CNT_W-2:0], 1'b0};
    assign depth_dec  = depth_reg - isa_pkg::CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            isa_pkg::ST_CLEAR:
            begin
                if (cnt_reg[isa_pkg::ADDR_W-1:0] == '1)
                begin
                    state_next = isa_pkg::ST_IDLE;
                end
            end
            isa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_kind)
                        isa_pkg::KIND_ALLOC:   state_next = isa_pkg::ST_ALLOC;
                        isa_pkg::KIND_CLAIM:   state_next = in_range ? isa_pkg::ST_GROW
                                                                     : isa_pkg::ST_DONE;
                        isa_pkg::KIND_RELEASE: state_next = in_range ? isa_pkg::ST_REL_CHK
                                                                     : isa_pkg::ST_DONE;
                        default:               state_next = isa_pkg::ST_DONE;
                    endcase
                end
            end
            isa_pkg::ST_GROW:
            begin
                if ({1'b0, slot_reg} < cap_reg)
                begin
                    state_next = isa_pkg::ST_CLAIM_CHK;
                end
            end
            isa_pkg::ST_CLAIM_CHK:
            begin
                state_next = isa_pkg::ST_DONE;
            end
            isa_pkg::ST_ALLOC:
            begin
                if (depth_reg != '0)
                begin
                    state_next = isa_pkg::ST_POP_WAIT;
                end
                else if (bump_reg < cap_reg)
                begin
                    state_next = isa_pkg::ST_ALLOC_CHK;
                end
                else if (bump_reg >= isa_pkg::MAX_CNT)
                begin
                    state_next = isa_pkg::ST_DONE;
                end
                else
                begin
                    state_next = isa_pkg::ST_ALLOC_CHK;
                end
            end
            isa_pkg::ST_POP_WAIT:
            begin
                state_next = isa_pkg::ST_ALLOC_CHK;
            end
            isa_pkg::ST_ALLOC_CHK:
            begin
                state_next = map_rdata ? isa_pkg::ST_ALLOC : isa_pkg::ST_DONE;
            end
            isa_pkg::ST_REL_CHK:
            begin
                if (!map_rdata)
                begin
                    state_next = isa_pkg::ST_DONE;
                end
                else if (depth_reg >= cap_reg)
                begin
                    state_next = isa_pkg::ST_CMP_MARK;
                end
                else
                begin
                    state_next = isa_pkg::ST_REL_PUSH;
                end
            end
            isa_pkg::ST_CMP_MARK:
            begin
                if (cnt_reg == depth_reg && !pend_reg)
                begin
                    state_next = isa_pkg::ST_CMP_SCAN;
                end
            end
            isa_pkg::ST_CMP_SCAN:
            begin
                if (cnt_reg == isa_pkg::MAX_CNT && !pend_reg)
                begin
                    state_next = isa_pkg::ST_REL_PUSH;
                end
            end
            isa_pkg::ST_REL_PUSH:
            begin
                state_next = isa_pkg::ST_DONE;
            end
            isa_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = isa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = isa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        slot_next     = slot_reg;
        idx_next      = idx_reg;
        scan_next     = scan_reg;
        depth_next    = depth_reg;
        bump_next     = bump_reg;
        cap_next      = cap_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        pend_next     = pend_reg;
        status_next   = status_reg;
        granted_next  = granted_reg;
        ostatus_next  = ostatus_reg;
        ogranted_next = ogranted_reg;
        ovalid_next   = (ovalid_reg && !out_ready);
        in_ready      = 1'b0;
        map_req       = '0;
        scr_req       = '0;
        stk_req       = '0;

        case (state_reg)
            isa_pkg::ST_CLEAR:
            begin
                map_req.we    = 1'b1;
                map_req.waddr = cnt_reg[isa_pkg::ADDR_W-1:0];
                scr_req.we    = 1'b1;
                scr_req.waddr = cnt_reg[isa_pkg::ADDR_W-1:0];
                cnt_next      = cnt_reg + isa_pkg::CNT_W'(1);
            end
            isa_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                map_req.raddr = in_slot;
                if (in_valid)
                begin
                    slot_next    = in_slot;
                    status_next  = isa_pkg::STATUS_OK;
                    granted_next = (in_kind == isa_pkg::KIND_ALLOC) ? '0 : in_slot;
                    if ((in_kind == isa_pkg::KIND_CLAIM || in_kind == isa_pkg::KIND_RELEASE)
                        && !in_range)
                    begin
                        status_next = isa_pkg::STATUS_RANGE;
                    end
                end
            end
            isa_pkg::ST_GROW:
            begin
                map_req.raddr = slot_reg;
                if ({1'b0, slot_reg} >= cap_reg)
                begin
                    cap_next = cap_grown;
                end
            end
            isa_pkg::ST_CLAIM_CHK:
            begin
                if (map_rdata)
                begin
                    status_next = isa_pkg::STATUS_IN_USE;
                end
                else
                begin
                    map_req.we    = 1'b1;
                    map_req.waddr = slot_reg;
                    map_req.wdata = 1'b1;
                end
            end
            isa_pkg::ST_ALLOC:
            begin
                if (depth_reg != '0)
                begin
                    depth_next    = depth_dec;
                    stk_req.raddr = depth_dec[isa_pkg::ADDR_W-1:0];
                end
                else if (bump_reg >= cap_reg && bump_reg >= isa_pkg::MAX_CNT)
                begin
                    status_next  = isa_pkg::STATUS_FULL;
                    granted_next = '0;
                end
                else
                begin
                    // The pointer has reached the capacity: double it first.
                    if (bump_reg >= cap_reg)
                    begin
                        cap_next = cap_grown;
                    end
                    idx_next      = bump_reg[isa_pkg::ADDR_W-1:0];
                    map_req.raddr = bump_reg[isa_pkg::ADDR_W-1:0];
                    bump_next     = bump_reg + isa_pkg::CNT_W'(1);
                end
            end
            isa_pkg::ST_POP_WAIT:
            begin
                idx_next      = stk_rdata;
                map_req.raddr = stk_rdata;
            end
            isa_pkg::ST_ALLOC_CHK:
            begin
                if (!map_rdata)
                begin
                    map_req.we    = 1'b1;
                    map_req.waddr = idx_reg;
                    map_req.wdata = 1'b1;
                    granted_next  = idx_reg;
                end
            end
            isa_pkg::ST_REL_CHK:
            begin
                cnt_next  = '0;
                pend_next = 1'b0;
            end
            isa_pkg::ST_CMP_MARK:
            begin
                // Read the stack entries in order and mark each value.
                pend_next = (cnt_reg < depth_reg);
                if (cnt_reg < depth_reg)
                begin
                    stk_req.raddr = cnt_reg[isa_pkg::ADDR_W-1:0];
                    cnt_next      = cnt_reg + isa_pkg::CNT_W'(1);
                end
                if (pend_reg)
                begin
                    scr_req.we    = 1'b1;
                    scr_req.waddr = stk_rdata;
                    scr_req.wdata = 1'b1;
                end
                if (cnt_reg == depth_reg && !pend_reg)
                begin
                    cnt_next = '0;
                    n_next   = '0;
                end
            end
            isa_pkg::ST_CMP_SCAN:
            begin
                // Sweep the scratch map, rebuilding the stack in ascending order
                // and clearing each mark in the cycle after its read.
                pend_next = (cnt_reg < isa_pkg::MAX_CNT);
                if (cnt_reg < isa_pkg::MAX_CNT)
                begin
                    scr_req.raddr = cnt_reg[isa_pkg::ADDR_W-1:0];
                    scan_next     = cnt_reg[isa_pkg::ADDR_W-1:0];
                    cnt_next      = cnt_reg + isa_pkg::CNT_W'(1);
                end
                if (pend_reg && scr_rdata)
                begin
                    stk_req.we    = 1'b1;
                    stk_req.waddr = n_reg[isa_pkg::ADDR_W-1:0];
                    stk_req.wdata = scan_reg;
                    scr_req.we    = 1'b1;
                    scr_req.waddr = scan_reg;
                    scr_req.wdata = 1'b0;
                    n_next        = n_reg + isa_pkg::CNT_W'(1);
                end
                if (cnt_reg == isa_pkg::MAX_CNT && !pend_reg)
                begin
                    depth_next = n_reg;
                end
            end
            isa_pkg::ST_REL_PUSH:
            begin
                map_req.we    = 1'b1;
                map_req.waddr = slot_reg;
                map_req.wdata = 1'b0;
                if (depth_reg < cap_reg && slot_range)
                begin
                    stk_req.we    = 1'b1;
                    stk_req.waddr = depth_reg[isa_pkg::ADDR_W-1:0];
                    stk_req.wdata = slot_reg;
                    depth_next    = depth_reg + isa_pkg::CNT_W'(1);
                end
            end
            isa_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next   = 1'b1;
                    ostatus_next  = status_reg;
                    ogranted_next = granted_reg;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= isa_pkg::ST_CLEAR;
            depth_reg  <= '0;
            bump_reg   <= '0;
            cap_reg    <= isa_pkg::MIN_CAP;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            depth_reg  <= depth_next;
            bump_reg   <= bump_next;
            cap_reg    <= cap_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        idx_reg      <= idx_next;
        scan_reg     <= scan_next;
        n_reg        <= n_next;
        status_reg   <= status_next;
        granted_reg  <= granted_next;
        ostatus_reg  <= ostatus_next;
        ogranted_reg <= ogranted_next;
    end

    assign out_valid   = ovalid_reg;
    assign out_status  = ostatus_reg;
    assign out_granted = ogranted_reg;
    assign stat.depth  = depth_reg;
    assign stat.bump   = bump_reg;
    assign stat.cap    = cap_reg;

endmodule
